>>> rtl/rsst_pkg.sv
package rsst_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_ELEMENTS_DEF = 65536;
    localparam int ELEMENT_BITS_DEF = 32;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int RANGE_W = 17;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 48;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    // Request kinds
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SQRT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LEAF_WR,
        ST_UP,
        ST_RD_L,
        ST_RD_R,
        ST_NODE_WR,
        ST_Q_LOOP,
        ST_Q_HI,
        ST_Q_SHIFT,
        ST_Q_FIN,
        ST_R_ROOT,
        ST_R_CHK,
        ST_R_RD,
        ST_R_GOT,
        ST_R_SQ,
        ST_R_SQLD,
        ST_R_NEXT
    } state_t;

    // Datapath commands, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CFG,
        OP_CLR,
        OP_LOAD,
        OP_RANGE,
        OP_RD_ROOT,
        OP_LEAF_WR,
        OP_UP,
        OP_RD_L,
        OP_RD_R,
        OP_NODE_WR,
        OP_Q_LO,
        OP_Q_HI,
        OP_SHIFT,
        OP_RD_P,
        OP_SQ_START,
        OP_SQ_LOAD,
        OP_NEXT_P,
        OP_OUT
    } dp_op_t;

    // Datapath status toward the controller
    typedef struct packed {
        logic range_empty;
        logic pos_full;
        logic clr_last;
        logic lo_lt_hi;
        logic lo_odd;
        logic hi_odd;
        logic node_gt1;
        logic root_gt1;
        logic leaf_gt1;
        logic p_last;
        logic sq_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/rsst_sqrt.sv
module rsst_sqrt #(
    parameter int VAL_W = rsst_pkg::ELEMENT_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [VAL_W-1:0] value,
    output logic             done,
    output logic [VAL_W-1:0] root
);

    localparam int H  = (VAL_W + 1) / 2;
    localparam int W2 = 2 * H;

    logic          run_reg, run_next;
    logic [W2-1:0] rem_reg, rem_next;
    logic [W2-1:0] root_reg, root_next;
    logic [W2-1:0] bit_reg, bit_next;
    logic [W2-1:0] trial;

    // One result bit per cycle, highest first
    always_comb
    begin
        trial     = root_reg + bit_reg;
        run_next  = run_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        done      = run_reg && (bit_reg == W2'(1));
        if (start)
        begin
            run_next  = 1'b1;
            rem_next  = W2'(value);
            root_next = '0;
            bit_next  = W2'(1) << (W2 - 2);
        end
        else if (run_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == W2'(1))
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign root = VAL_W'(root_reg);

endmodule

>>> rtl/rsst_ctrl.sv
module rsst_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [rsst_pkg::CMD_W-1:0]   in_cmd,
    input  logic                         cfg_valid,
    input  rsst_pkg::dp_status_t         status,
    output logic                         in_ready,
    output logic                         cfg_ready,
    output rsst_pkg::dp_op_t             op
);

    rsst_pkg::state_t state_reg, state_next;
    logic             sqrt_mode_reg, sqrt_mode_next;

    // Advance the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsst_pkg::ST_IDLE;
            sqrt_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sqrt_mode_reg <= sqrt_mode_next;
        end
    end

    // Next state and datapath command
    always_comb
    begin
        state_next     = state_reg;
        sqrt_mode_next = sqrt_mode_reg;
        op             = rsst_pkg::OP_NONE;
        cfg_ready      = (state_reg == rsst_pkg::ST_IDLE);
        in_ready       = (state_reg == rsst_pkg::ST_IDLE) && !cfg_valid;
        unique case (state_reg)
            rsst_pkg::ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    op         = rsst_pkg::OP_CFG;
                    state_next = rsst_pkg::ST_CLEAR;
                end
                else if (in_valid)
                begin
                    case (in_cmd)
                        rsst_pkg::CMD_LOAD:
                        begin
                            if (!status.pos_full)
                            begin
                                op             = rsst_pkg::OP_LOAD;
                                sqrt_mode_next = 1'b0;
                                state_next     = rsst_pkg::ST_LEAF_WR;
                            end
                        end
                        rsst_pkg::CMD_QUERY:
                        begin
                            op         = rsst_pkg::OP_RANGE;
                            state_next = rsst_pkg::ST_Q_LOOP;
                        end
                        rsst_pkg::CMD_SQRT:
                        begin
                            if (!status.range_empty)
                            begin
                                op         = rsst_pkg::OP_RANGE;
                                state_next = rsst_pkg::ST_R_ROOT;
                            end
                        end
                        default:
                        begin
                            op = rsst_pkg::OP_NONE;
                        end
                    endcase
                end
            end
            // Zero the node store after a size write
            rsst_pkg::ST_CLEAR:
            begin
                op = rsst_pkg::OP_CLR;
                if (status.clr_last)
                begin
                    state_next = rsst_pkg::ST_IDLE;
                end
            end
            // Leaf write and walk toward the root
            rsst_pkg::ST_LEAF_WR:
            begin
                op         = rsst_pkg::OP_LEAF_WR;
                state_next = rsst_pkg::ST_UP;
            end
            rsst_pkg::ST_UP:
            begin
                if (status.node_gt1)
                begin
                    op         = rsst_pkg::OP_UP;
                    state_next = rsst_pkg::ST_RD_L;
                end
                else if (sqrt_mode_reg)
                begin
                    state_next = rsst_pkg::ST_R_NEXT;
                end
                else
                begin
                    state_next = rsst_pkg::ST_IDLE;
                end
            end
            rsst_pkg::ST_RD_L:
            begin
                op         = rsst_pkg::OP_RD_L;
                state_next = rsst_pkg::ST_RD_R;
            end
            rsst_pkg::ST_RD_R:
            begin
                op         = rsst_pkg::OP_RD_R;
                state_next = rsst_pkg::ST_NODE_WR;
            end
            rsst_pkg::ST_NODE_WR:
            begin
                op         = rsst_pkg::OP_NODE_WR;
                state_next = rsst_pkg::ST_UP;
            end
            // Range sum walk
            rsst_pkg::ST_Q_LOOP:
            begin
                if (!status.lo_lt_hi)
                begin
                    state_next = rsst_pkg::ST_Q_FIN;
                end
                else
                begin
                    if (status.lo_odd)
                    begin
                        op = rsst_pkg::OP_Q_LO;
                    end
                    state_next = rsst_pkg::ST_Q_HI;
                end
            end
            rsst_pkg::ST_Q_HI:
            begin
                if (status.hi_odd)
                begin
                    op = rsst_pkg::OP_Q_HI;
                end
                state_next = rsst_pkg::ST_Q_SHIFT;
            end
            rsst_pkg::ST_Q_SHIFT:
            begin
                op         = rsst_pkg::OP_SHIFT;
                state_next = rsst_pkg::ST_Q_LOOP;
            end
            rsst_pkg::ST_Q_FIN:
            begin
                if (status.out_free)
                begin
                    op         = rsst_pkg::OP_OUT;
                    state_next = rsst_pkg::ST_IDLE;
                end
            end
            // Range square root
            rsst_pkg::ST_R_ROOT:
            begin
                op         = rsst_pkg::OP_RD_ROOT;
                state_next = rsst_pkg::ST_R_CHK;
            end
            rsst_pkg::ST_R_CHK:
            begin
                state_next = status.root_gt1 ? rsst_pkg::ST_R_RD : rsst_pkg::ST_IDLE;
            end
            rsst_pkg::ST_R_RD:
            begin
                op         = rsst_pkg::OP_RD_P;
                state_next = rsst_pkg::ST_R_GOT;
            end
            rsst_pkg::ST_R_GOT:
            begin
                if (status.leaf_gt1)
                begin
                    op         = rsst_pkg::OP_SQ_START;
                    state_next = rsst_pkg::ST_R_SQ;
                end
                else
                begin
                    state_next = rsst_pkg::ST_R_NEXT;
                end
            end
            rsst_pkg::ST_R_SQ:
            begin
                if (status.sq_done)
                begin
                    state_next = rsst_pkg::ST_R_SQLD;
                end
            end
            rsst_pkg::ST_R_SQLD:
            begin
                op             = rsst_pkg::OP_SQ_LOAD;
                sqrt_mode_next = 1'b1;
                state_next     = rsst_pkg::ST_LEAF_WR;
            end
            rsst_pkg::ST_R_NEXT:
            begin
                if (status.p_last)
                begin
                    state_next = rsst_pkg::ST_IDLE;
                end
                else
                begin
                    op         = rsst_pkg::OP_NEXT_P;
                    state_next = rsst_pkg::ST_R_RD;
                end
            end
            default:
            begin
                state_next = rsst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/rsst_dp.sv
module rsst_dp #(
    parameter int MAX_ELEMENTS = rsst_pkg::MAX_ELEMENTS_DEF,
    parameter int ELEMENT_BITS = rsst_pkg::ELEMENT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rsst_pkg::dp_op_t                 op,
    input  logic [rsst_pkg::RANGE_W-1:0]     range_left,
    input  logic [rsst_pkg::RANGE_W-1:0]     range_right,
    input  logic [rsst_pkg::VALUE_W-1:0]     element_value,
    input  logic [rsst_pkg::RANGE_W-1:0]     cfg_data,
    input  logic                             out_ready,
    output rsst_pkg::dp_status_t             status,
    output logic                             out_valid,
    output logic [rsst_pkg::SUM_W-1:0]       out_sum
);

    localparam int SW     = rsst_pkg::SUM_W;
    localparam int RW     = rsst_pkg::RANGE_W;
    localparam int N_W    = $clog2(MAX_ELEMENTS + 1);
    localparam int NODES  = 2 * MAX_ELEMENTS;
    localparam int NODE_W = $clog2(NODES);
    localparam int XW     = ((N_W > RW) ? N_W : RW) + 1;
    localparam int LW     = ((NODE_W > XW) ? NODE_W : XW) + 1;

    // Node sums and maxima, one read and one write port
    logic [SW-1:0]           sums_mem [NODES];
    logic [ELEMENT_BITS-1:0] maxs_mem [NODES];

    logic [N_W-1:0]          size_reg, pos_reg, p_reg, right_reg;
    logic [NODE_W-1:0]       node_reg;
    logic [LW-1:0]           lo_reg, hi_reg;
    logic [SW-1:0]           acc_reg, lsum_reg, sum_q;
    logic [ELEMENT_BITS-1:0] val_reg, lmax_reg, max_q;
    logic                    pend_reg;
    logic                    out_valid_reg;
    logic [SW-1:0]           out_sum_reg;

    logic [XW-1:0]           cfg_x, left_x, right_x, size_x;
    logic [LW-1:0]           lo_init, hi_init, hi_dec;
    logic [NODE_W-1:0]       leaf_p, leaf_pos, lchild, rchild, clr_end;
    logic                    rd_en, wr_en;
    logic [NODE_W-1:0]       rd_addr;
    logic [SW-1:0]           wr_sum;
    logic [ELEMENT_BITS-1:0] wr_max;
    logic                    sq_done;
    logic [ELEMENT_BITS-1:0] sq_root;

    // Clamp the size write and the request range
    always_comb
    begin
        cfg_x = XW'(cfg_data);
        if (cfg_x == '0)
        begin
            cfg_x = XW'(1);
        end
        else if (cfg_x > XW'(MAX_ELEMENTS))
        begin
            cfg_x = XW'(MAX_ELEMENTS);
        end
        size_x = XW'(size_reg);
        left_x = XW'(range_left);
        if (left_x == '0)
        begin
            left_x = XW'(1);
        end
        right_x = XW'(range_right);
        if (right_x > size_x)
        begin
            right_x = size_x;
        end
    end

    // Tree addresses
    assign lo_init  = LW'(size_reg) + LW'(left_x) - LW'(1);
    assign hi_init  = LW'(size_reg) + LW'(right_x);
    assign hi_dec   = hi_reg - LW'(1);
    assign leaf_p   = NODE_W'(LW'(size_reg) + LW'(p_reg) - LW'(1));
    assign leaf_pos = NODE_W'(LW'(size_reg) + LW'(pos_reg));
    assign lchild   = node_reg << 1;
    assign rchild   = lchild | NODE_W'(1);
    assign clr_end  = NODE_W'((LW'(size_reg) << 1) - LW'(1));

    // Memory port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = node_reg;
        wr_en   = 1'b0;
        wr_sum  = SW'(val_reg);
        wr_max  = val_reg;
        case (op)
            rsst_pkg::OP_RD_ROOT:
            begin
                rd_en   = 1'b1;
                rd_addr = NODE_W'(1);
            end
            rsst_pkg::OP_RD_L:
            begin
                rd_en   = 1'b1;
                rd_addr = lchild;
            end
            rsst_pkg::OP_RD_R:
            begin
                rd_en   = 1'b1;
                rd_addr = rchild;
            end
            rsst_pkg::OP_Q_LO:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg[NODE_W-1:0];
            end
            rsst_pkg::OP_Q_HI:
            begin
                rd_en   = 1'b1;
                rd_addr = hi_dec[NODE_W-1:0];
            end
            rsst_pkg::OP_RD_P:
            begin
                rd_en   = 1'b1;
                rd_addr = leaf_p;
            end
            rsst_pkg::OP_CLR:
            begin
                wr_en  = 1'b1;
                wr_sum = '0;
                wr_max = '0;
            end
            rsst_pkg::OP_LEAF_WR:
            begin
                wr_en = 1'b1;
            end
            rsst_pkg::OP_NODE_WR:
            begin
                wr_en  = 1'b1;
                wr_sum = lsum_reg + sum_q;
                wr_max = (lmax_reg > max_q) ? lmax_reg : max_q;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sum_q <= sums_mem[rd_addr];
            max_q <= maxs_mem[rd_addr];
        end
        if (wr_en)
        begin
            sums_mem[node_reg] <= wr_sum;
            maxs_mem[node_reg] <= wr_max;
        end
    end

    // Square-root unit
    rsst_sqrt #(
        .VAL_W (ELEMENT_BITS)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (op == rsst_pkg::OP_SQ_START),
        .value (ELEMENT_BITS'(sum_q)),
        .done  (sq_done),
        .root  (sq_root)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= N_W'(1);
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= (op == rsst_pkg::OP_Q_LO) || (op == rsst_pkg::OP_Q_HI);
            if (op == rsst_pkg::OP_CFG)
            begin
                size_reg <= N_W'(cfg_x);
                pos_reg  <= '0;
            end
            else if (op == rsst_pkg::OP_LOAD)
            begin
                pos_reg <= pos_reg + N_W'(1);
            end
            if (op == rsst_pkg::OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            acc_reg <= acc_reg + sum_q;
        end
        case (op)
            rsst_pkg::OP_CFG:
            begin
                node_reg <= NODE_W'(1);
            end
            rsst_pkg::OP_CLR:
            begin
                node_reg <= node_reg + NODE_W'(1);
            end
            rsst_pkg::OP_LOAD:
            begin
                node_reg <= leaf_pos;
                val_reg  <= ELEMENT_BITS'(element_value);
            end
            rsst_pkg::OP_RANGE:
            begin
                lo_reg    <= lo_init;
                hi_reg    <= hi_init;
                p_reg     <= N_W'(left_x);
                right_reg <= N_W'(right_x);
                acc_reg   <= '0;
            end
            rsst_pkg::OP_UP:
            begin
                node_reg <= node_reg >> 1;
            end
            rsst_pkg::OP_RD_R:
            begin
                lsum_reg <= sum_q;
                lmax_reg <= max_q;
            end
            rsst_pkg::OP_Q_LO:
            begin
                lo_reg <= lo_reg + LW'(1);
            end
            rsst_pkg::OP_Q_HI:
            begin
                hi_reg <= hi_dec;
            end
            rsst_pkg::OP_SHIFT:
            begin
                lo_reg <= lo_reg >> 1;
                hi_reg <= hi_reg >> 1;
            end
            rsst_pkg::OP_RD_P:
            begin
                node_reg <= leaf_p;
            end
            rsst_pkg::OP_SQ_LOAD:
            begin
                val_reg <= sq_root;
            end
            rsst_pkg::OP_NEXT_P:
            begin
                p_reg <= p_reg + N_W'(1);
            end
            rsst_pkg::OP_OUT:
            begin
                out_sum_reg <= acc_reg;
            end
            default:
            begin
                node_reg <= node_reg;
            end
        endcase
    end

    // Status toward the controller
    always_comb
    begin
        status.range_empty = left_x > right_x;
        status.pos_full    = pos_reg >= size_reg;
        status.clr_last    = node_reg == clr_end;
        status.lo_lt_hi    = lo_reg < hi_reg;
        status.lo_odd      = lo_reg[0];
        status.hi_odd      = hi_reg[0];
        status.node_gt1    = node_reg > NODE_W'(1);
        status.root_gt1    = max_q > ELEMENT_BITS'(1);
        status.leaf_gt1    = sum_q > SW'(1);
        status.p_last      = p_reg == right_reg;
        status.sq_done     = sq_done;
        status.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

endmodule

>>> rtl/range_sqrt_sum_tree_unit.sv
// Range square-root sum tree. Holds up to MAX_ELEMENTS unsigned elements in a
// bottom-up binary sum tree (node sums and maxima in on-chip memory with one
// read and one write port). Writing cfg_data sets the element count, restarts
// loading at position 1 and zeroes every element: nodes 1 to 2*size-1 are
// cleared one per cycle, so a size write keeps both ports closed until the
// clear is done. Requests are taken one at a time. A load walks from the leaf
// to the root through ST_UP, ST_RD_L, ST_RD_R and ST_NODE_WR at each level.
// A query goes through ST_Q_LOOP, ST_Q_HI and ST_Q_SHIFT at each tree level,
// then hands the sum to the output register once that is free, which lets
// the next request in while the result waits. A square-root request reads
// each leaf of the range; a leaf above 1 also passes through the bit-serial
// root unit and a leaf-to-root update, so its length grows with the range.
// If the whole array is at most 1, a square-root request ends after the
// root check without reading any leaf.
module range_sqrt_sum_tree_unit #(
    parameter int MAX_ELEMENTS = rsst_pkg::MAX_ELEMENTS_DEF,
    parameter int ELEMENT_BITS = rsst_pkg::ELEMENT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // range_left [16:0], range_right [33:17], element_value [65:34], zero pad
    input  logic [rsst_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // cmd [1:0]
    input  logic [rsst_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // range_sum [47:0]
    output logic [rsst_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsst_pkg::RANGE_W-1:0]        cfg_data
);

    localparam int RW = rsst_pkg::RANGE_W;

    rsst_pkg::dp_op_t     op;
    rsst_pkg::dp_status_t status;

    rsst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .cfg_valid (cfg_valid),
        .status    (status),
        .in_ready  (s_axis_tready),
        .cfg_ready (cfg_ready),
        .op        (op)
    );

    rsst_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .range_left    (s_axis_tdata[RW-1:0]),
        .range_right   (s_axis_tdata[2*RW-1:RW]),
        .element_value (s_axis_tdata[2*RW+rsst_pkg::VALUE_W-1:2*RW]),
        .cfg_data      (cfg_data),
        .out_ready     (m_axis_tready),
        .status        (status),
        .out_valid     (m_axis_tvalid),
        .out_sum       (m_axis_tdata)
    );

    // A request and a size write never land on the same edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !(cfg_valid && cfg_ready))
    else $error("request and size write accepted together");

    // Requests are only open when the size port is open too
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> cfg_ready)
    else $error("request port open while size port closed");

endmodule
